>>> design/dqpb_pkg.sv
`default_nettype none

package dqpb_pkg;

    localparam int CNT_W       = 6;
    localparam int ECNT_W      = 7;
    localparam int HDR_LEN     = 12;
    localparam int TRL_LEN     = 5;
    localparam int MAX_RESULTS = 64;

    localparam logic [7:0]  DOT_CHAR  = 8'h2E;
    localparam logic [15:0] HDR_FLAGS = 16'h0100;

    typedef enum logic [1:0] {
        SEL_HDR,
        SEL_LEN,
        SEL_DATA,
        SEL_TRL
    } dqpb_sel_t;

    typedef struct packed {
        logic             accept;
        logic             start_name;
        logic             close_name;
        logic             store;
        logic             set_ovf;
        logic             clr_count;
        logic             rd_en;
        logic [CNT_W-1:0] rd_addr;
        logic             emit;
        dqpb_sel_t        sel;
        logic [CNT_W-1:0] idx;
        logic             lor;
        logic             eop;
    } dqpb_cmd_t;

    typedef struct packed {
        logic             in_name;
        logic             is_dot;
        logic             last;
        logic             room;
        logic [CNT_W-1:0] count;
        logic             out_free;
    } dqpb_stat_t;

    // id, flags, qdcount 1, other counts 0
    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
        logic [7:0] b;
        begin
            unique case (idx)
                4'd0:    b = id[15:8];
                4'd1:    b = id[7:0];
                4'd2:    b = HDR_FLAGS[15:8];
                4'd3:    b = HDR_FLAGS[7:0];
                4'd5:    b = 8'h01;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    // terminator, type 1, class 1
    function automatic logic [7:0] trl_byte(input logic [2:0] idx);
        logic [7:0] b;
        begin
            unique case (idx)
                3'd2:    b = 8'h01;
                3'd4:    b = 8'h01;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/dqpb_datapath.sv
`default_nettype none

module dqpb_datapath
    import dqpb_pkg::*;
#(
    parameter int MAX_LABEL = 32,
    parameter int AW        = 5
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_char,
    input  wire logic       in_last,
    input  wire dqpb_cmd_t  cmd,
    output dqpb_stat_t      st,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic [1:0]      m_tuser
);

    logic [7:0]       char_reg;
    logic             last_reg;
    logic [15:0]      qc_reg;
    logic             inside_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       rd_data_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             lor_reg;
    logic             eop_reg;
    logic             ovf_out_reg;
    logic [7:0]       byte_next;

    logic [7:0] mem [MAX_LABEL];

    always_comb
    begin
        st.in_name  = inside_reg;
        st.is_dot   = (char_reg == DOT_CHAR);
        st.last     = last_reg;
        st.room     = (count_reg < CNT_W'(MAX_LABEL));
        st.count    = count_reg;
        st.out_free = !valid_reg || m_tready;
    end

    always_comb
    begin
        unique case (cmd.sel)
            SEL_HDR:  byte_next = hdr_byte(cmd.idx[3:0], qc_reg);
            SEL_LEN:  byte_next = {{(8-CNT_W){1'b0}}, count_reg};
            SEL_DATA: byte_next = rd_data_reg;
            SEL_TRL:  byte_next = trl_byte(cmd.idx[2:0]);
            default:  byte_next = 8'h00;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
        if (cmd.store)
        begin
            mem[count_reg[AW-1:0]] <= char_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr[AW-1:0]];
        end
        if (cmd.emit)
        begin
            byte_reg    <= byte_next;
            lor_reg     <= cmd.lor;
            eop_reg     <= cmd.eop;
            ovf_out_reg <= cmd.eop && ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qc_reg     <= '0;
            inside_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start_name)
            begin
                qc_reg     <= qc_reg + 16'd1;
                inside_reg <= 1'b1;
                ovf_reg    <= 1'b0;
            end
            else if (cmd.close_name)
            begin
                inside_reg <= 1'b0;
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.store)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = lor_reg;
    assign m_tuser  = {ovf_out_reg, eop_reg};

endmodule

`default_nettype wire

>>> design/dqpb_ctrl.sv
`default_nettype none

module dqpb_ctrl
    import dqpb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dqpb_stat_t st,
    output dqpb_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_PROC,
        ST_FLEN,
        ST_FDATA,
        ST_TRL
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [ECNT_W-1:0] ecnt_reg, ecnt_next;
    logic              final_reg, final_next;
    state_t            after_flush;
    logic              flush_final;
    logic              cap;

    assign s_tready = (state_reg == ST_IDLE);
    assign cap      = (ecnt_reg == ECNT_W'(MAX_RESULTS - 1));

    // where to go once a label has been flushed
    always_comb
    begin
        flush_final = 1'b0;
        if (st.last && !final_reg)
        begin
            after_flush = ST_FLEN;
            flush_final = 1'b1;
        end
        else if (final_reg)
        begin
            after_flush = ST_TRL;
        end
        else
        begin
            after_flush = ST_IDLE;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.idx    = idx_reg;
        state_next = state_reg;
        idx_next   = idx_reg;
        ecnt_next  = ecnt_reg;
        final_next = final_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    ecnt_next  = '0;
                    final_next = 1'b0;
                    idx_next   = '0;
                    if (!st.in_name)
                    begin
                        cmd.start_name = 1'b1;
                        state_next     = ST_HDR;
                    end
                    else
                    begin
                        state_next = ST_PROC;
                    end
                end
            end
            ST_HDR:
            begin
                cmd.sel = SEL_HDR;
                if (st.out_free)
                begin
                    cmd.emit  = 1'b1;
                    ecnt_next = ecnt_reg + ECNT_W'(1);
                    if (idx_reg == CNT_W'(HDR_LEN - 1))
                    begin
                        cmd.lor    = !st.last;
                        state_next = ST_PROC;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_PROC:
            begin
                if (st.is_dot && st.count != '0)
                begin
                    state_next = ST_FLEN;
                end
                else
                begin
                    cmd.store   = st.room;
                    cmd.set_ovf = !st.room;
                    if (st.last)
                    begin
                        final_next = 1'b1;
                        state_next = ST_FLEN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLEN:
            begin
                cmd.sel = SEL_LEN;
                if (st.out_free)
                begin
                    cmd.emit  = 1'b1;
                    ecnt_next = ecnt_reg + ECNT_W'(1);
                    idx_next  = '0;
                    if (st.count == '0)
                    begin
                        cmd.clr_count = 1'b1;
                        cmd.lor       = !final_reg && !st.last;
                        final_next    = final_reg || flush_final;
                        state_next    = after_flush;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = '0;
                        state_next  = ST_FDATA;
                    end
                end
            end
            ST_FDATA:
            begin
                cmd.sel = SEL_DATA;
                if (st.out_free)
                begin
                    cmd.emit  = 1'b1;
                    ecnt_next = ecnt_reg + ECNT_W'(1);
                    if ((idx_reg + CNT_W'(1)) == st.count)
                    begin
                        cmd.clr_count = 1'b1;
                        cmd.lor       = !final_reg && !st.last;
                        final_next    = final_reg || flush_final;
                        idx_next      = '0;
                        state_next    = after_flush;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = idx_reg + CNT_W'(1);
                        idx_next    = idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_TRL:
            begin
                cmd.sel = SEL_TRL;
                if (st.out_free)
                begin
                    cmd.emit  = 1'b1;
                    ecnt_next = ecnt_reg + ECNT_W'(1);
                    if (idx_reg == CNT_W'(TRL_LEN - 1) || cap)
                    begin
                        cmd.lor        = 1'b1;
                        cmd.eop        = 1'b1;
                        cmd.close_name = 1'b1;
                        idx_next       = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            ecnt_reg  <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ecnt_reg  <= ecnt_next;
            final_reg <= final_next;
        end
    end

endmodule

`default_nettype wire

>>> design/dns_query_packet_builder.sv
// channel   dir  tdata          tlast          tuser
// s_axis    in   name_char      last_of_name   -
// m_axis    out  out_byte       last_of_run    end_of_packet, label_overflow
//
// a character is accepted, then stored or decided on; each byte that it adds is then sent
// the first character of a name adds the 12 header bytes; the last adds length, label,
// terminator and type/class bytes, one per cycle unless stalled; label via buffer read port
// reset clears the query id, label count and name state; the label buffer is not cleared
// a stalled output holds the sequencer; s_tready is high only between characters
`default_nettype none

module dns_query_packet_builder
    import dqpb_pkg::*;
#(
    parameter int MAX_LABEL = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // name_char
    input  wire logic       s_tlast,   // last_of_name
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // last_of_run
    output logic [1:0]      m_tuser    // end_of_packet, label_overflow
);

    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    dqpb_cmd_t  cmd;
    dqpb_stat_t st;

    dqpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dqpb_datapath #(
        .MAX_LABEL (MAX_LABEL),
        .AW        (AW)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
